/* sv/aevo_pkg.sv */
// shared types, constants and saturation helper for the velocity observer
// no dependencies; imported by every module of the block
package aevo_pkg;

  // default structure sizes
  localparam int WINDOW_DEF = 10;
  localparam int FRAC_DEF   = 16;

  // field widths
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int SAT_W     = 66;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN1_START   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN2_START   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE1         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE2         = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] TS_RESET    = 31'd655;
  localparam logic [CFG_W-1:0] G1_RESET    = 31'd65536000;
  localparam logic [CFG_W-1:0] G2_RESET    = 31'd6553600;
  localparam logic [CFG_W-1:0] RATE1_RESET = 31'd655;
  localparam logic [CFG_W-1:0] RATE2_RESET = 31'd1311;

  // clamp limits on the wide signed scale
  localparam logic signed [SAT_W-1:0] S32_HI = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] S32_LO = -S32_HI - SAT_W'(64'sd1);
  localparam logic signed [SAT_W-1:0] U31_HI = SAT_W'(64'sd2147483647);

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_M6,
    S_M7,
    S_M8,
    S_DIV,
    S_DONE
  } state_t;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > S32_HI) begin
      r = S32_HI[DATA_W-1:0];
    end else if (v < S32_LO) begin
      r = S32_LO[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/aevo_mul.sv */
// shared fixed-point multiplier: registered 32x32 signed product
// result is the product shifted right by the fraction bits (floor); uses aevo_pkg
module aevo_mul #(
  parameter int FRAC_BITS = aevo_pkg::FRAC_DEF
) (
  input  logic                                   clk,
  input  logic signed [aevo_pkg::DATA_W-1:0]     mul_a,
  input  logic signed [aevo_pkg::DATA_W-1:0]     mul_b,
  output logic signed [2*aevo_pkg::DATA_W-FRAC_BITS-1:0] mul_q
);
  import aevo_pkg::*;

  localparam int PW = 2 * DATA_W;

  logic signed [PW-1:0] prod_r;

  // product register, one multiplication per cycle
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // arithmetic shift rounds towards minus infinity
  assign mul_q = prod_r[PW-1:FRAC_BITS];

endmodule

/* sv/aevo_div.sv */
// restoring divider, one quotient bit per cycle
// used for the window mean; uses aevo_pkg for the status struct
module aevo_div #(
  parameter int NW = 35,
  parameter int DW = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [NW-1:0]            dividend,
  input  logic [DW-1:0]            divisor,
  output aevo_pkg::div_stat_t      stat,
  output logic [NW-1:0]            quotient
);
  import aevo_pkg::*;

  localparam int SCW = $clog2(NW + 1);

  logic [SCW-1:0] step_r;
  logic [DW:0]    rem_r;
  logic [NW-1:0]  quo_r;
  logic [DW-1:0]  div_r;
  logic           busy_r;
  logic           done_r;
  logic [DW:0]    shifted;
  logic           fits;

  // trial subtract of the next remainder
  always_comb begin
    shifted = {rem_r[DW-1:0], quo_r[NW-1]};
    fits    = (shifted >= {1'b0, div_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + SCW'(1);
        if (step_r == SCW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (shifted - {1'b0, div_r}) : shifted;
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

/* sv/adaptive_encoder_velocity_observer.sv */
// top level of the adaptive encoder velocity observer
// sequencer, state registers and error window; uses aevo_pkg, aevo_mul, aevo_div
//
// Usage:
//   Input channel in_valid/in_stall carries one signed Q16.16 position sample
//   per transfer. Output channel out_valid/out_stall carries the estimates used
//   for that sample, the adapted gains and the mean squared innovation.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); write
//   only while no sample is in flight. Writing a start gain also reloads the
//   running gain at once; unknown indexes are ignored.
//   A sample goes through steps S_M1 to S_M8 on the single shared 32x32
//   multiplier, then through S_DIV on the bit-serial divider that forms the
//   window mean of the SUMW-bit window sum, SUMW = 31 + clog2(WINDOW+1), then
//   through S_DONE. in_stall is high from the transfer until the sequencer is
//   back in S_IDLE, so no new sample is taken before the last one is through.
//   A finished result sits in the output register; the next sample may be
//   taken meanwhile, and the sequencer holds its own result until the output
//   register is free.
//   Reset: estimates and the window sum clear, gains load their default start
//   values, registers take their defaults. The window store needs no clearing.
module adaptive_encoder_velocity_observer #(
  parameter int WINDOW    = aevo_pkg::WINDOW_DEF,
  parameter int FRAC_BITS = aevo_pkg::FRAC_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [aevo_pkg::DATA_W-1:0]   in_position,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [aevo_pkg::DATA_W-1:0]   out_position_estimate,
  output logic signed [aevo_pkg::DATA_W-1:0]   out_velocity_estimate,
  output logic signed [aevo_pkg::DATA_W-1:0]   out_acceleration_estimate,
  output logic signed [aevo_pkg::DATA_W-1:0]   out_gain1_now,
  output logic signed [aevo_pkg::DATA_W-1:0]   out_gain2_now,
  output logic        [aevo_pkg::CFG_W-1:0]    out_mean_sq_error,
  input  logic                                 cfg_we,
  input  logic        [aevo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [aevo_pkg::CFG_W-1:0]    cfg_wdata
);
  import aevo_pkg::*;

  localparam int QW   = 2 * DATA_W - FRAC_BITS;
  localparam int SW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int SUMW = CFG_W + CW;

  // sequencer and control
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   div_start;
  div_stat_t div_stat;

  // configuration registers
  logic [CFG_W-1:0] ts_r, ts_nxt;
  logic [CFG_W-1:0] rate1_r, rate1_nxt;
  logic [CFG_W-1:0] rate2_r, rate2_nxt;

  // observer state
  logic signed [DATA_W-1:0] pos_r, pos_nxt;
  logic signed [DATA_W-1:0] vel_r, vel_nxt;
  logic signed [DATA_W-1:0] gpos_r, gpos_nxt;
  logic signed [DATA_W-1:0] gvel_r, gvel_nxt;
  logic [SUMW-1:0]          sum_r, sum_nxt;
  logic [SW-1:0]            slot_r, slot_nxt;
  logic                     filled_r, filled_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;

  // per-sample working registers
  logic signed [DATA_W-1:0] e_r, e_nxt;
  logic signed [QW-1:0]     t1_r, t1_nxt;
  logic signed [DATA_W-1:0] ae_r, ae_nxt;
  logic [CFG_W-1:0]         sq_r, sq_nxt;
  logic signed [DATA_W-1:0] xe_h_r, xe_h_nxt;
  logic signed [DATA_W-1:0] ve_h_r, ve_h_nxt;

  // output registers
  logic signed [DATA_W-1:0] o_xe_r, o_xe_nxt;
  logic signed [DATA_W-1:0] o_ve_r, o_ve_nxt;
  logic signed [DATA_W-1:0] o_ae_r, o_ae_nxt;
  logic signed [DATA_W-1:0] o_g1_r, o_g1_nxt;
  logic signed [DATA_W-1:0] o_g2_r, o_g2_nxt;
  logic [CFG_W-1:0]         o_mse_r, o_mse_nxt;

  // window store
  logic [CFG_W-1:0] err_mem [WINDOW];
  logic [CFG_W-1:0] rd_r;

  // shared multiplier and divider
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [QW-1:0]     mul_q;
  logic [SUMW-1:0]          quotient;
  logic [CFG_W-1:0]         mean;
  logic signed [SAT_W-1:0]  q_ext;

  aevo_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_q (mul_q)
  );

  aevo_div #(
    .NW (SUMW),
    .DW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  assign q_ext = SAT_W'(mul_q);
  assign mean  = (|quotient[SUMW-1:CFG_W]) ? '1 : quotient[CFG_W-1:0];

  // multiplier operand selection per step
  always_comb begin
    unique case (state_r)
      S_M1:    begin mul_a = gpos_r; mul_b = e_r; end
      S_M2:    begin mul_a = gvel_r; mul_b = vel_r; end
      S_M4:    begin mul_a = $signed({1'b0, rate1_r}); mul_b = e_r; end
      S_M5:    begin mul_a = $signed({1'b0, rate2_r}); mul_b = vel_r; end
      S_M6:    begin mul_a = vel_r; mul_b = $signed({1'b0, ts_r}); end
      S_M7:    begin mul_a = ae_r;  mul_b = $signed({1'b0, ts_r}); end
      default: begin mul_a = e_r;   mul_b = e_r; end
    endcase
  end

  // sequencer, next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    ts_nxt        = ts_r;
    rate1_nxt     = rate1_r;
    rate2_nxt     = rate2_r;
    pos_nxt       = pos_r;
    vel_nxt       = vel_r;
    gpos_nxt      = gpos_r;
    gvel_nxt      = gvel_r;
    sum_nxt       = sum_r;
    slot_nxt      = slot_r;
    filled_nxt    = filled_r;
    cnt_nxt       = cnt_r;
    e_nxt         = e_r;
    t1_nxt        = t1_r;
    ae_nxt        = ae_r;
    sq_nxt        = sq_r;
    xe_h_nxt      = xe_h_r;
    ve_h_nxt      = ve_h_r;
    o_xe_nxt      = o_xe_r;
    o_ve_nxt      = o_ve_r;
    o_ae_nxt      = o_ae_r;
    o_g1_nxt      = o_g1_r;
    o_g2_nxt      = o_g2_r;
    o_mse_nxt     = o_mse_r;

    // result taken by the receiver
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          e_nxt     = sat32(SAT_W'(in_position) - SAT_W'(pos_r));
          xe_h_nxt  = pos_r;
          ve_h_nxt  = vel_r;
          state_nxt = S_M1;
        end
      end
      S_M1: state_nxt = S_M2;
      S_M2: begin
        t1_nxt    = mul_q;
        state_nxt = S_M3;
      end
      S_M3: begin
        ae_nxt    = sat32(SAT_W'(t1_r) - q_ext);
        state_nxt = S_M4;
      end
      S_M4: begin
        sq_nxt    = (q_ext > U31_HI) ? '1 : mul_q[CFG_W-1:0];
        state_nxt = S_M5;
      end
      S_M5: begin
        gpos_nxt = sat32(SAT_W'(gpos_r) + q_ext);
        // window sum: drop the overwritten entry once the window is full
        sum_nxt  = sum_r - (filled_r ? SUMW'(rd_r) : '0) + SUMW'(sq_r);
        if (slot_r == SW'(WINDOW - 1)) begin
          slot_nxt   = '0;
          filled_nxt = 1'b1;
          cnt_nxt    = CW'(WINDOW);
        end else begin
          slot_nxt = slot_r + SW'(1);
          cnt_nxt  = filled_r ? CW'(WINDOW) : (CW'(slot_r) + CW'(1));
        end
        state_nxt = S_M6;
      end
      S_M6: begin
        gvel_nxt  = sat32(SAT_W'(gvel_r) - q_ext);
        state_nxt = S_M7;
      end
      S_M7: begin
        pos_nxt   = sat32(SAT_W'(pos_r) + q_ext);
        state_nxt = S_M8;
      end
      S_M8: begin
        vel_nxt   = sat32(SAT_W'(vel_r) + q_ext);
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          o_xe_nxt      = xe_h_r;
          o_ve_nxt      = ve_h_r;
          o_ae_nxt      = ae_r;
          o_g1_nxt      = gpos_r;
          o_g2_nxt      = gvel_r;
          o_mse_nxt     = mean;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // configuration writes, which the user makes only while idle; the block itself does not enforce it
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_PERIOD: ts_nxt    = cfg_wdata;
        CFG_GAIN1_START:   gpos_nxt  = $signed({1'b0, cfg_wdata});
        CFG_GAIN2_START:   gvel_nxt  = $signed({1'b0, cfg_wdata});
        CFG_RATE1:         rate1_nxt = cfg_wdata;
        CFG_RATE2:         rate2_nxt = cfg_wdata;
        default:           ;
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ts_r        <= TS_RESET;
      rate1_r     <= RATE1_RESET;
      rate2_r     <= RATE2_RESET;
      pos_r       <= '0;
      vel_r       <= '0;
      gpos_r      <= $signed({1'b0, G1_RESET});
      gvel_r      <= $signed({1'b0, G2_RESET});
      sum_r       <= '0;
      slot_r      <= '0;
      filled_r    <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ts_r        <= ts_nxt;
      rate1_r     <= rate1_nxt;
      rate2_r     <= rate2_nxt;
      pos_r       <= pos_nxt;
      vel_r       <= vel_nxt;
      gpos_r      <= gpos_nxt;
      gvel_r      <= gvel_nxt;
      sum_r       <= sum_nxt;
      slot_r      <= slot_nxt;
      filled_r    <= filled_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    e_r     <= e_nxt;
    t1_r    <= t1_nxt;
    ae_r    <= ae_nxt;
    sq_r    <= sq_nxt;
    xe_h_r  <= xe_h_nxt;
    ve_h_r  <= ve_h_nxt;
    o_xe_r  <= o_xe_nxt;
    o_ve_r  <= o_ve_nxt;
    o_ae_r  <= o_ae_nxt;
    o_g1_r  <= o_g1_nxt;
    o_g2_r  <= o_g2_nxt;
    o_mse_r <= o_mse_nxt;
  end

  // window store: read the oldest entry early, overwrite it later
  always_ff @(posedge clk) begin
    if (state_r == S_M1) begin
      rd_r <= err_mem[slot_r];
    end
    if (state_r == S_M5) begin
      err_mem[slot_r] <= sq_r;
    end
  end

  // ports
  assign in_stall                  = (state_r != S_IDLE);
  assign out_valid                 = out_valid_r;
  assign out_position_estimate     = o_xe_r;
  assign out_velocity_estimate     = o_ve_r;
  assign out_acceleration_estimate = o_ae_r;
  assign out_gain1_now             = o_g1_r;
  assign out_gain2_now             = o_g2_r;
  assign out_mean_sq_error         = o_mse_r;

  // checks
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_M8) |=> div_stat.busy)
    else $error("divider did not start");

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r |-> (cnt_r == CW'(WINDOW)))
    else $error("full window with short entry count");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !(out_valid_r && out_stall)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("finished result not presented");

endmodule
